[src/vector3_normalize_top_defines.svh]
// ----------------------------------------------------------------------------
// vector3_normalize_top_defines
// Assertion macros used by the top level of the 3D vector normalizer.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_NORMALIZE_TOP_DEFINES_SVH
`define VECTOR3_NORMALIZE_TOP_DEFINES_SVH

// same-cycle implication
`define VN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VN_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/vn_pkg.sv]
// ----------------------------------------------------------------------------
// vn_pkg
// Types and constants of the 3D vector normalizer.
// ----------------------------------------------------------------------------
package vn_pkg;

    localparam int COMP_W     = 32;
    localparam int SUM_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int QUOT_W     = 31;
    localparam int SQ_STAGES  = ROOT_W;
    localparam int DIV_STAGES = QUOT_W;
    localparam logic [QUOT_W-1:0] Q30_ONE = QUOT_W'(1) << 30;

    typedef struct packed {
        logic [COMP_W-1:0] mag;
        logic              neg;
    } comp_t;

endpackage

[src/vn_sqrt.sv]
// ----------------------------------------------------------------------------
// vn_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module vn_sqrt
    import vn_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [SUM_W-1:0]  in_sum,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int REM_W = ROOT_W + 4;

    logic              valid_reg [SQ_STAGES];
    logic [SUM_W-1:0]  sum_reg   [SQ_STAGES];
    logic [REM_W-1:0]  rem_reg   [SQ_STAGES];
    logic [ROOT_W-1:0] root_reg  [SQ_STAGES];
    logic [SIDE_W-1:0] side_reg  [SQ_STAGES];

    genvar i;
    generate
        for (i = 0; i < SQ_STAGES; i++)
        begin : g_stage
            logic              v_prev;
            logic [SUM_W-1:0]  s_prev;
            logic [REM_W-1:0]  r_prev;
            logic [ROOT_W-1:0] q_prev;
            logic [SIDE_W-1:0] d_prev;
            logic [REM_W-1:0]  rem_sh;
            logic [REM_W-1:0]  trial;
            logic              take;

            if (i == 0)
            begin : g_first
                assign v_prev = in_valid;
                assign s_prev = in_sum;
                assign r_prev = '0;
                assign q_prev = '0;
                assign d_prev = in_side;
            end
            else
            begin : g_rest
                assign v_prev = valid_reg[i-1];
                assign s_prev = sum_reg[i-1];
                assign r_prev = rem_reg[i-1];
                assign q_prev = root_reg[i-1];
                assign d_prev = side_reg[i-1];
            end

            assign rem_sh = {r_prev[REM_W-3:0], s_prev[SUM_W-1-2*i -: 2]};
            assign trial  = REM_W'({q_prev, 2'b01});
            assign take   = (rem_sh >= trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[i] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[i] <= v_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sum_reg[i]  <= s_prev;
                    rem_reg[i]  <= take ? (rem_sh - trial) : rem_sh;
                    root_reg[i] <= {q_prev[ROOT_W-2:0], take};
                    side_reg[i] <= d_prev;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[SQ_STAGES-1];
    assign out_root  = root_reg[SQ_STAGES-1];
    assign out_side  = side_reg[SQ_STAGES-1];

endmodule

[src/vn_div.sv]
// ----------------------------------------------------------------------------
// vn_div
// One lane: pipelined rounded division (mag * 2^30 + len/2) / len,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module vn_div
    import vn_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  comp_t             in_comp,
    input  logic [ROOT_W-1:0] in_len,
    output logic [QUOT_W-1:0] out_quot,
    output logic              out_neg
);

    localparam int DVD_W = COMP_W + 31;
    localparam int REM_W = ROOT_W + 1;

    logic [DVD_W-1:0]  dvd_reg [DIV_STAGES];
    logic [ROOT_W-1:0] len_reg [DIV_STAGES];
    logic [ROOT_W-1:0] rem_reg [DIV_STAGES];
    logic [QUOT_W-1:0] quo_reg [DIV_STAGES];
    logic              neg_reg [DIV_STAGES];

    logic [DVD_W-1:0] dvd_in;

    assign dvd_in = (DVD_W'(in_comp.mag) << 30) + DVD_W'(in_len >> 1);

    genvar j;
    generate
        for (j = 0; j < DIV_STAGES; j++)
        begin : g_stage
            logic [DVD_W-1:0]  d_prev;
            logic [ROOT_W-1:0] l_prev;
            logic [ROOT_W-1:0] r_prev;
            logic [QUOT_W-1:0] q_prev;
            logic              n_prev;
            logic [REM_W-1:0]  rem_sh;
            logic              take;

            if (j == 0)
            begin : g_first
                assign d_prev = dvd_in;
                assign l_prev = in_len;
                assign r_prev = dvd_in[DVD_W-1 -: ROOT_W];
                assign q_prev = '0;
                assign n_prev = in_comp.neg;
            end
            else
            begin : g_rest
                assign d_prev = dvd_reg[j-1];
                assign l_prev = len_reg[j-1];
                assign r_prev = rem_reg[j-1];
                assign q_prev = quo_reg[j-1];
                assign n_prev = neg_reg[j-1];
            end

            assign rem_sh = {r_prev, d_prev[QUOT_W-1-j]};
            assign take   = (rem_sh >= REM_W'(l_prev));

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dvd_reg[j] <= d_prev;
                    len_reg[j] <= l_prev;
                    rem_reg[j] <= take ? ROOT_W'(rem_sh - REM_W'(l_prev))
                                       : ROOT_W'(rem_sh);
                    quo_reg[j] <= {q_prev[QUOT_W-2:0], take};
                    neg_reg[j] <= n_prev;
                end
            end
        end
    endgenerate

    assign out_quot = quo_reg[DIV_STAGES-1];
    assign out_neg  = neg_reg[DIV_STAGES-1];

endmodule

[src/vector3_normalize_top.sv]
// Throughput: one item per cycle; the 32-stage root and 31-stage divider
// pipelines advance together and stall as a whole while the output waits.
// Reset: rst_n asynchronous, clears valid flags only; no clearing pass.
// ----------------------------------------------------------------------------
// vector3_normalize_top
// Normalizes a Q16.16 3D vector to Q1.30 with Q16.16 length, three divider
// lanes behind a shared square root pipeline.
// ----------------------------------------------------------------------------
module vector3_normalize_top
    import vn_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // vec_x, vec_y, vec_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // unit_x, unit_y, unit_z, length
    output logic         m_tuser    // zero_error
);

`include "vector3_normalize_top_defines.svh"

    localparam int SIDE_W = 3 * $bits(comp_t);

    logic en;

    comp_t               a_comp_reg [3];
    logic                a_valid_reg;
    comp_t               b_comp_reg [3];
    logic [SUM_W-1:0]    b_sq_reg   [3];
    logic                b_valid_reg;
    comp_t               c_comp_reg [3];
    logic [SUM_W-1:0]    c_sum_reg;
    logic                c_valid_reg;

    logic                sq_valid;
    logic [ROOT_W-1:0]   sq_root;
    logic [SIDE_W-1:0]   sq_side;

    logic                dl_valid_reg [DIV_STAGES];
    logic [ROOT_W-1:0]   dl_len_reg   [DIV_STAGES];

    logic [QUOT_W-1:0]   lane_quot [3];
    logic                lane_neg  [3];

    logic                out_valid_reg;
    logic [127:0]        out_data_reg;
    logic                out_zero_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= s_tvalid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                a_comp_reg[k].neg <= s_tdata[32*k+31];
                a_comp_reg[k].mag <= s_tdata[32*k+31] ? (~s_tdata[32*k +: 32]) + 32'd1
                                                      : s_tdata[32*k +: 32];
                b_comp_reg[k] <= a_comp_reg[k];
                b_sq_reg[k]   <= SUM_W'(a_comp_reg[k].mag) * SUM_W'(a_comp_reg[k].mag);
                c_comp_reg[k] <= b_comp_reg[k];
            end
            c_sum_reg <= b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];
        end
    end

    vn_sqrt #(
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_valid_reg),
        .in_sum    (c_sum_reg),
        .in_side   ({c_comp_reg[2], c_comp_reg[1], c_comp_reg[0]}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_lane
            vn_div u_div (
                .clk      (clk),
                .en       (en),
                .in_comp  (comp_t'(sq_side[g*$bits(comp_t) +: $bits(comp_t)])),
                .in_len   (sq_root),
                .out_quot (lane_quot[g]),
                .out_neg  (lane_neg[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                dl_valid_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            dl_valid_reg[0] <= sq_valid;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                dl_valid_reg[k] <= dl_valid_reg[k-1];
            end
            out_valid_reg <= dl_valid_reg[DIV_STAGES-1];
        end
    end

    // merge: clamp, sign, zero-length override
    always_ff @(posedge clk)
    begin
        logic [QUOT_W-1:0] q;
        logic              zero;
        if (en)
        begin
            dl_len_reg[0] <= sq_root;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                dl_len_reg[k] <= dl_len_reg[k-1];
            end
            zero = (dl_len_reg[DIV_STAGES-1] == '0);
            for (int k = 0; k < 3; k++)
            begin
                q = (lane_quot[k] > Q30_ONE) ? Q30_ONE : lane_quot[k];
                if (zero)
                begin
                    out_data_reg[32*k +: 32] <= '0;
                end
                else
                begin
                    out_data_reg[32*k +: 32] <= lane_neg[k] ? 32'd0 - 32'(q) : 32'(q);
                end
            end
            out_data_reg[127:96] <= zero ? '0 : dl_len_reg[DIV_STAGES-1];
            out_zero_reg         <= zero;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_zero_reg;

    `VN_ASSERT_IMP(a_zero_units, m_tvalid && m_tuser, m_tdata == '0, "zero flag with data")
    `VN_ASSERT_IMP(a_len_nonzero, m_tvalid && !m_tuser, m_tdata[127:96] != '0,
                   "zero length without flag")
    `VN_ASSERT_IMP(a_ready, 1'b1, s_tready == (!m_tvalid || m_tready), "ready mismatch")
    `VN_ASSERT_NXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
                   "result changed under stall")

endmodule

[sim/vector3_normalize_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_normalize_checker
// Watches both stream channels of the normalizer, computes the expected unit
// vector, length and zero flag for each accepted item, and compares in order.
// ----------------------------------------------------------------------------
module vector3_normalize_checker
    import vn_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [95:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    input  logic         m_tuser,
    output int           fail_count,
    output int           pending
);

    typedef struct packed {
        logic        zero_flag;
        logic [31:0] len;
        logic [31:0] uz;
        logic [31:0] uy;
        logic [31:0] ux;
    } norm_result_t;

    norm_result_t expected_q[$];

    function automatic logic [31:0] int_sqrt(logic [63:0] s);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        rem  = s;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
    endfunction

    function automatic logic [31:0] unit_of(logic [31:0] c, logic [31:0] len);
        logic [63:0] mag;
        logic [63:0] q;
        mag = c[31] ? {32'd0, -c} : {32'd0, c};
        if (c == 32'h8000_0000)
            mag = 64'h8000_0000;
        q = ((mag << 30) + (len >> 1)) / len;
        if (q > 64'd1 << 30)
            q = 64'd1 << 30;
        return c[31] ? -q[31:0] : q[31:0];
    endfunction

    function automatic norm_result_t normalize(logic [95:0] v);
        norm_result_t r;
        logic [31:0]  c [3];
        logic [63:0]  sum;
        logic [63:0]  m;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            c[i] = v[32*i +: 32];
            m = c[i][31] ? {32'd0, -c[i]} : {32'd0, c[i]};
            if (c[i] == 32'h8000_0000)
                m = 64'h8000_0000;
            sum = sum + m * m;
        end
        r = '0;
        r.len = int_sqrt(sum);
        if (r.len == 0)
            r.zero_flag = 1'b1;
        else
        begin
            r.ux = unit_of(c[0], r.len);
            r.uy = unit_of(c[1], r.len);
            r.uz = unit_of(c[2], r.len);
        end
        return r;
    endfunction

    assign pending = expected_q.size();

    initial fail_count = 0;

    always @(posedge clk)
    begin
        norm_result_t e;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_q.push_back(normalize(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected, actual %h %b",
                             $time, m_tdata, m_tuser);
                    fail_count++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (m_tdata[31:0] !== e.ux)
                    begin
                        $display("%0t: unit_x expected %h actual %h", $time, e.ux,
                                 m_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_tdata[63:32] !== e.uy)
                    begin
                        $display("%0t: unit_y expected %h actual %h", $time, e.uy,
                                 m_tdata[63:32]);
                        fail_count++;
                    end
                    if (m_tdata[95:64] !== e.uz)
                    begin
                        $display("%0t: unit_z expected %h actual %h", $time, e.uz,
                                 m_tdata[95:64]);
                        fail_count++;
                    end
                    if (m_tdata[127:96] !== e.len)
                    begin
                        $display("%0t: length expected %h actual %h", $time, e.len,
                                 m_tdata[127:96]);
                        fail_count++;
                    end
                    if (m_tuser !== e.zero_flag)
                    begin
                        $display("%0t: zero_error expected %b actual %b", $time,
                                 e.zero_flag, m_tuser);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives directed and random vectors into the normalizer with random gaps on
// both streams, a long output hold-off and a drain pause, then reports.
// ----------------------------------------------------------------------------
module tb;
    import vn_pkg::*;

    localparam int LATENCY     = 67;
    localparam int CYCLE_LIMIT = 400000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic         m_tuser;
    int           fail_count;
    int           pending;
    int           cycle_count;
    bit           hold_off;
    bit           calm;

    vector3_normalize_top uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    vector3_normalize_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        hold_off = 1'b0;
        calm     = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= calm || ($urandom_range(99) >= 20);
    end

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(65536 * 4)) - 131072);
            2: return 32'($signed($urandom_range(255)) - 128);
            3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            4: return 32'd0;
            default: return $urandom >> $urandom_range(31);
        endcase
    endfunction

    task automatic send(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        while (!calm && $urandom_range(99) < 20)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        @(posedge clk);
        send(0, 0, 0);
        send(32'h0001_0000, 0, 0);
        send(0, 32'hFFFF_0000, 0);
        send(0, 0, 32'h8000_0000);
        send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send(32'h7FFF_FFFF, 32'h8000_0000, 0);
        send(1, 0, 0);
        send(32'hFFFF_FFFF, 0, 0);
        send(1, 1, 1);
        send(1, 1, 0);
        send(3, 0, 4);
        send(32'h0003_0000, 32'hFFFC_0000, 32'h000C_0000);
        send(2, 3, 5);
        send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
        drain();
        for (int i = 0; i < 1050; i++)
        begin
            calm = (i >= 300 && i < 420);
            if (i == 500)
            begin
                hold_off = 1'b1;
                fork
                    begin
                        repeat (300) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            if (i == 800)
                drain();
            send(rand_comp(), rand_comp(), rand_comp());
        end
        drain();
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/vn_pkg.sv
src/vn_sqrt.sv
src/vn_div.sv
src/vector3_normalize_top.sv
sim/vector3_normalize_checker.sv
sim/tb.sv
